### sv/obt_pkg.sv
// ----------------------------------------------------------------------------
// obt_pkg
// Shared types and constants of the outstanding buffer tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package obt_pkg;

    // Defaults of the top-level parameters.
    localparam int DEPTH_DEF     = 32;
    localparam int KEY_WIDTH_DEF = 32;

    // Fixed widths of the stream fields.
    localparam int FUNC_W  = 2;
    localparam int KEY_W   = 32;
    localparam int TAG_W   = 8;
    localparam int TAGS_W  = 3 * TAG_W;
    localparam int SLOT_W  = 5;
    localparam int LIVE_W  = 6;
    localparam int DUMP_W  = 32;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 104;
    localparam int OUT_PAD_W  = OUT_DATA_W - (SLOT_W + KEY_W + TAGS_W + LIVE_W + DUMP_W);

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DUMP   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_INSERTED   = 3'd0,
        ST_FULL       = 3'd1,
        ST_FREED      = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_DUMP_ENTRY = 3'd4,
        ST_DUMP_TOTAL = 3'd5,
        ST_BAD_KEY    = 3'd6
    } t_status;

    // One result item as produced by the sequencer.
    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]    key;
        logic [TAG_W-1:0]    src;
        logic [TAG_W-1:0]    dst;
        logic [TAG_W-1:0]    evt;
        logic [LIVE_W-1:0]   live;
        logic [DUMP_W-1:0]   dump;
        logic                last;
    } t_result;

endpackage

`default_nettype wire

### sv/obt_ram.sv
// ----------------------------------------------------------------------------
// obt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module obt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### sv/obt_scan.sv
// ----------------------------------------------------------------------------
// obt_scan
// Slot sequencer: walks one slot index over the table with a single key
// comparator, keeps valid bits, the live count and the dump number.
// ----------------------------------------------------------------------------
`default_nettype none

module obt_scan #(
    parameter int DEPTH    = 32,
    parameter int KEY_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [obt_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [obt_pkg::KEY_W-1:0]     i_key,
    input  wire logic [obt_pkg::TAGS_W-1:0]    i_tags,
    input  wire logic                          i_out_free,
    input  wire logic [KEY_BITS-1:0]           i_rd_key,
    input  wire logic [obt_pkg::TAGS_W-1:0]    i_rd_tags,
    output logic                               o_ready,
    output logic                               o_emit,
    output obt_pkg::t_result                   o_result,
    output logic [$clog2(DEPTH)-1:0]           o_rd_addr,
    output logic                               o_wr_en,
    output logic [$clog2(DEPTH)-1:0]           o_wr_addr,
    output logic [KEY_BITS-1:0]                o_wr_key,
    output logic [obt_pkg::TAGS_W-1:0]         o_wr_tags
);

    import obt_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_FINAL = 3'b100
    } t_state;

    t_state              r_state,  n_state;
    logic [FUNC_W-1:0]   r_func,   n_func;
    logic [KEY_BITS-1:0] r_key,    n_key;
    logic [TAGS_W-1:0]   r_tags,   n_tags;
    logic [IW-1:0]       r_idx,    n_idx;
    logic [DEPTH-1:0]    r_valid,  n_valid;
    logic [CW-1:0]       r_count,  n_count;
    logic [DUMP_W-1:0]   r_dump,   n_dump;
    t_status             r_fin,    n_fin;

    logic                cur_valid;
    logic                last_idx;
    logic                hit;
    logic [KEY_BITS-1:0] in_key;

    assign in_key    = i_key[KEY_BITS-1:0];
    assign cur_valid = r_valid[r_idx];
    assign last_idx  = (r_idx == IW'(DEPTH - 1));
    assign hit       = cur_valid && (i_rd_key == r_key);

    // The read address is the next index and the RAM read is registered, so the
    // RAM data seen in a cycle belongs to the current slot.
    assign o_rd_addr = n_idx;
    assign o_ready   = (r_state == S_IDLE);
    assign o_wr_addr = r_idx;
    assign o_wr_key  = r_key;
    assign o_wr_tags = r_tags;

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_func   = r_func;
        n_key    = r_key;
        n_tags   = r_tags;
        n_idx    = r_idx;
        n_valid  = r_valid;
        n_count  = r_count;
        n_dump   = r_dump;
        n_fin    = r_fin;
        o_emit   = 1'b0;
        o_result = '0;
        o_wr_en  = 1'b0;

        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_start) begin
                    n_func = i_func;
                    n_key  = in_key;
                    n_tags = i_tags;
                    case (i_func)
                        FN_INSERT: begin
                            if (in_key == '0) begin
                                n_fin   = ST_BAD_KEY;
                                n_state = S_FINAL;
                            end else if (r_count >= CW'(DEPTH)) begin
                                n_fin   = ST_FULL;
                                n_state = S_FINAL;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        FN_FREE: begin
                            if (in_key == '0) begin
                                n_fin   = ST_BAD_KEY;
                                n_state = S_FINAL;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        FN_DUMP: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                case (r_func)
                    FN_INSERT: begin
                        if (!cur_valid) begin
                            // Lowest free slot found: write it once the
                            // result can be delivered.
                            if (i_out_free) begin
                                o_emit          = 1'b1;
                                o_wr_en         = 1'b1;
                                n_valid[r_idx]  = 1'b1;
                                n_count         = r_count + CW'(1);
                                o_result.status = ST_INSERTED;
                                o_result.slot   = SLOT_W'(r_idx);
                                o_result.key    = KEY_W'(r_key);
                                o_result.src    = r_tags[23:16];
                                o_result.dst    = r_tags[15:8];
                                o_result.evt    = r_tags[7:0];
                                o_result.live   = LIVE_W'(n_count);
                                o_result.last   = 1'b1;
                                n_state         = S_IDLE;
                            end
                        end else if (last_idx) begin
                            n_fin   = ST_FULL;
                            n_state = S_FINAL;
                        end else begin
                            n_idx = r_idx + IW'(1);
                        end
                    end
                    FN_FREE: begin
                        if (hit) begin
                            if (i_out_free) begin
                                o_emit          = 1'b1;
                                n_valid[r_idx]  = 1'b0;
                                if (r_count != '0) begin
                                    n_count = r_count - CW'(1);
                                end
                                o_result.status = ST_FREED;
                                o_result.slot   = SLOT_W'(r_idx);
                                o_result.key    = KEY_W'(i_rd_key);
                                o_result.src    = i_rd_tags[23:16];
                                o_result.dst    = i_rd_tags[15:8];
                                o_result.evt    = i_rd_tags[7:0];
                                o_result.live   = LIVE_W'(n_count);
                                o_result.last   = 1'b1;
                                n_state         = S_IDLE;
                            end
                        end else if (last_idx) begin
                            n_fin   = ST_NOT_FOUND;
                            n_state = S_FINAL;
                        end else begin
                            n_idx = r_idx + IW'(1);
                        end
                    end
                    default: begin
                        // Dump: report each valid slot, stalling on the
                        // output as needed.
                        if (!cur_valid || i_out_free) begin
                            if (cur_valid) begin
                                o_emit          = 1'b1;
                                o_result.status = ST_DUMP_ENTRY;
                                o_result.slot   = SLOT_W'(r_idx);
                                o_result.key    = KEY_W'(i_rd_key);
                                o_result.src    = i_rd_tags[23:16];
                                o_result.dst    = i_rd_tags[15:8];
                                o_result.evt    = i_rd_tags[7:0];
                                o_result.live   = LIVE_W'(r_count);
                                o_result.dump   = r_dump;
                            end
                            if (last_idx) begin
                                n_fin   = ST_DUMP_TOTAL;
                                n_state = S_FINAL;
                            end else begin
                                n_idx = r_idx + IW'(1);
                            end
                        end
                    end
                endcase
            end

            S_FINAL: begin
                // Single closing result without entry fields.
                if (i_out_free) begin
                    o_emit          = 1'b1;
                    o_result.status = r_fin;
                    o_result.live   = LIVE_W'(r_count);
                    o_result.last   = 1'b1;
                    if (r_fin == ST_DUMP_TOTAL) begin
                        o_result.dump = r_dump;
                        n_dump        = r_dump + DUMP_W'(1);
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_count <= '0;
            r_dump  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_count <= n_count;
            r_dump  <= n_dump;
            r_idx   <= n_idx;
        end
    end

    // Operation payload.
    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_key  <= n_key;
        r_tags <= n_tags;
        r_fin  <= n_fin;
    end

endmodule

`default_nettype wire

### sv/outstanding_buffer_tracker.sv
// ----------------------------------------------------------------------------
// outstanding_buffer_tracker
// Table of outstanding buffers with insert, free and dump operations.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  tdata fields (low bit first)                      tuser   tlast
//  s_axis    in   key, src_entity, dst_entity, event_tag            func    -
//  m_axis    out  slot, entry_key, entry_src, entry_dst,            status  last
//                 entry_event, live_count, dump_number, zero pad
//
// One item at a time: a single slot index walks the table, one slot per cycle
// while the output does not stall, against one read address shared by the key
// and tag RAMs and a single key comparator. Reset clears valid bits, the live
// count and the dump number at once; the key and tag RAMs need no clearing pass.
// The result register lets the next item enter while the last result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module outstanding_buffer_tracker #(
    parameter int DEPTH     = obt_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = obt_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // key[31:0], src_entity[39:32], dst_entity[47:40], event_tag[55:48]
    input  wire logic [obt_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // func[1:0]
    input  wire logic [obt_pkg::FUNC_W-1:0]        i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // slot[4:0], entry_key[36:5], entry_src[44:37], entry_dst[52:45],
    // entry_event[60:53], live_count[66:61], dump_number[98:67], zero[103:99]
    output logic [obt_pkg::OUT_DATA_W-1:0]         o_m_axis_tdata,
    // status[2:0]
    output logic [2:0]                             o_m_axis_tuser,
    output logic                                   o_m_axis_tlast
);

    import obt_pkg::*;

    localparam int KW = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
    localparam int IW = $clog2(DEPTH);

    logic              w_accept;
    logic              w_ready;
    logic              w_emit;
    logic              w_out_free;
    t_result           w_result;
    logic [IW-1:0]     w_rd_addr;
    logic              w_wr_en;
    logic [IW-1:0]     w_wr_addr;
    logic [KW-1:0]     w_wr_key;
    logic [TAGS_W-1:0] w_wr_tags;
    logic [KW-1:0]     w_rd_key;
    logic [TAGS_W-1:0] w_rd_tags;
    logic [TAGS_W-1:0] w_in_tags;

    logic              r_out_vld;
    t_result           r_out;

    assign o_s_axis_tready = w_ready;
    assign w_accept        = i_s_axis_tvalid && w_ready;
    assign w_out_free      = !r_out_vld || i_m_axis_tready;
    assign w_in_tags       = {i_s_axis_tdata[39:32], i_s_axis_tdata[47:40],
                              i_s_axis_tdata[55:48]};

    // Key and tag stores.
    obt_ram #(
        .WIDTH (KW),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_key),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_key)
    );

    obt_ram #(
        .WIDTH (TAGS_W),
        .DEPTH (DEPTH)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_tags),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_tags)
    );

    // Slot sequencer.
    obt_scan #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_func     (i_s_axis_tuser),
        .i_key      (i_s_axis_tdata[31:0]),
        .i_tags     (w_in_tags),
        .i_out_free (w_out_free),
        .i_rd_key   (w_rd_key),
        .i_rd_tags  (w_rd_tags),
        .o_ready    (w_ready),
        .o_emit     (w_emit),
        .o_result   (w_result),
        .o_rd_addr  (w_rd_addr),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_wr_key   (w_wr_key),
        .o_wr_tags  (w_wr_tags)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_emit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out.dump, r_out.live, r_out.evt,
                              r_out.dst, r_out.src, r_out.key, r_out.slot};

    // A result is only produced when the output register can take it.
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_out_free)
        else $error("result produced while output register is occupied");

    // Any real operation leaves the block busy in the cycle after it is accepted.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_s_axis_tuser != FN_UNUSED)) |=> !o_s_axis_tready)
        else $error("ready stayed high after an operation was accepted");

    // The final result of an operation returns the sequencer to idle.
    a_last_ends_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_result.last) |=> o_s_axis_tready)
        else $error("sequencer still busy after the final result");

    // Dump entries never close an operation.
    a_entry_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && (w_result.status == ST_DUMP_ENTRY)) |-> !w_result.last)
        else $error("dump entry marked as final result");

endmodule

`default_nettype wire
